// ===== sv/dmmac_pkg.sv =====
// ----------------------------------------------------------------------------
// dmmac_pkg
// Shared types, constants and helpers for the daily mean moving average block.
// ----------------------------------------------------------------------------
package dmmac_pkg;

    localparam int MAX_DAYS   = 32;
    localparam int RING_AW    = $clog2(MAX_DAYS);
    localparam int IDX_W      = RING_AW + 1;
    localparam int PERIOD_W   = 6;
    localparam int COUNT_BITS = 16;
    localparam int TEMP_W     = 16;
    localparam int SUM_W      = TEMP_W + COUNT_BITS;
    localparam int TOTAL_W    = TEMP_W + RING_AW;
    localparam int DIV_W      = SUM_W;
    localparam int DIV_CW     = $clog2(DIV_W) + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_AVG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP   = 2'd2;

    localparam logic [PERIOD_W-1:0]      AVG_PERIOD_RST = 6'd7;
    localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST   = 16'sd256;
    localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST   = 16'sd5120;

    typedef struct packed {
        logic signed [TEMP_W-1:0] outdoor_temp;
        logic                     at_midnight;
    } t_in_item;

    typedef struct packed {
        logic signed [TEMP_W-1:0] soil_temp;
        logic                     day_closed;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_MEAN,
        ST_FILL,
        ST_WRITE,
        ST_SUM,
        ST_AVG_LOAD,
        ST_DIV_AVG,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic take_mean;
        logic fill_step;
        logic write_one;
        logic sum_step;
        logic load_avg;
        logic finish;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic close_now;
        logic div_busy;
        logic need_fill;
        logic fill_last;
        logic sum_done;
        logic out_free;
    } t_sts;

    // ring length in use, limited to 1..MAX_DAYS
    function automatic logic [IDX_W-1:0] period_of(input logic [PERIOD_W-1:0] v);
        logic [IDX_W-1:0] p;
        if (v == '0) begin
            p = IDX_W'(1);
        end else if (v > PERIOD_W'(MAX_DAYS)) begin
            p = IDX_W'(MAX_DAYS);
        end else begin
            p = IDX_W'(v);
        end
        return p;
    endfunction

endpackage

// ===== sv/daily_mean_moving_average_clamp.sv =====
// ----------------------------------------------------------------------------
// daily_mean_moving_average_clamp
// Moving average of daily temperature means over a ring of days, clamped
// to a configurable range; one result beat per sample beat.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        sink       i_in_valid / o_in_ready    i_in_data  (t_in_item)
//  out       source     o_out_valid / i_out_ready  o_out_data (t_out_item)
//  cfg       sink       i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  a beat that closes no day is accepted, then loaded into the output register once it is free
//  a closing beat (P = ring length) makes two passes of the shared 32-step
//  divider, plus a ring fill of all P entries or a single write and a sum
//  over the P ring entries
//  the next beat is taken while a result still sits in the output register
//  synchronous active-low reset; no clearing pass; unless the ring length grows,
//  ring entries are written before they are read
// ----------------------------------------------------------------------------
module daily_mean_moving_average_clamp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [dmmac_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dmmac_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  dmmac_pkg::t_in_item                   i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output dmmac_pkg::t_out_item                  o_out_data
);

    dmmac_pkg::t_cmd cmd;
    dmmac_pkg::t_sts sts;

    dmmac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dmmac_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // the divider is always idle when a new beat can be taken
    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !sts.div_busy)
        else $error("input ready while divider still running");

    // a result is never loaded over one that has not been taken
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded while output register busy");

    // the controller issues at most one datapath step per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.take_mean, cmd.fill_step, cmd.write_one,
                  cmd.sum_step, cmd.load_avg, cmd.finish, cmd.emit}))
        else $error("overlapping datapath commands");
`endif

endmodule

// ===== sv/dmmac_div.sv =====
// ----------------------------------------------------------------------------
// dmmac_div
// Shared signed-by-unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module dmmac_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic signed [dmmac_pkg::DIV_W-1:0]   i_dividend,
    input  logic [dmmac_pkg::COUNT_BITS-1:0]     i_divisor,
    output logic                                 o_busy,
    output logic signed [dmmac_pkg::DIV_W-1:0]   o_quotient
);

    logic [dmmac_pkg::DIV_W-1:0]      r_quo;
    logic [dmmac_pkg::COUNT_BITS-1:0] r_rem;
    logic [dmmac_pkg::COUNT_BITS-1:0] r_den;
    logic                             r_neg;
    logic [dmmac_pkg::DIV_CW-1:0]     r_cnt;
    logic                             r_busy;

    logic [dmmac_pkg::COUNT_BITS:0]   shifted;
    logic [dmmac_pkg::COUNT_BITS:0]   trial;
    logic                             fits;

    assign shifted = {r_rem, r_quo[dmmac_pkg::DIV_W-1]};
    assign trial   = shifted - {1'b0, r_den};
    assign fits    = ~trial[dmmac_pkg::COUNT_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= dmmac_pkg::DIV_CW'(dmmac_pkg::DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == dmmac_pkg::DIV_CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg <= i_dividend[dmmac_pkg::DIV_W-1];
            r_quo <= i_dividend[dmmac_pkg::DIV_W-1] ? -i_dividend : i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? trial[dmmac_pkg::COUNT_BITS-1:0]
                          : shifted[dmmac_pkg::COUNT_BITS-1:0];
            r_quo <= {r_quo[dmmac_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

// ===== sv/dmmac_dp.sv =====
// ----------------------------------------------------------------------------
// dmmac_dp
// Datapath: config registers, day accumulator, ring memory with sweep,
// shared divider, clamp and the output register.
// ----------------------------------------------------------------------------
module dmmac_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [dmmac_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dmmac_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  dmmac_pkg::t_in_item                   i_in_data,
    input  dmmac_pkg::t_cmd                       i_cmd,
    output dmmac_pkg::t_sts                       o_sts,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output dmmac_pkg::t_out_item                  o_out_data
);

    localparam int SUM_W   = dmmac_pkg::SUM_W;
    localparam int TEMP_W  = dmmac_pkg::TEMP_W;
    localparam int TOTAL_W = dmmac_pkg::TOTAL_W;
    localparam int DIV_W   = dmmac_pkg::DIV_W;
    localparam int IDX_W   = dmmac_pkg::IDX_W;
    localparam int RING_AW = dmmac_pkg::RING_AW;

    // configuration
    logic [dmmac_pkg::PERIOD_W-1:0] r_avg_period;
    logic signed [TEMP_W-1:0]       r_min_temp;
    logic signed [TEMP_W-1:0]       r_max_temp;

    // day accumulator and ring state
    logic signed [SUM_W-1:0]             r_day_sum;
    logic [dmmac_pkg::COUNT_BITS-1:0]    r_step_count;
    logic                                r_need_fill;
    logic [RING_AW-1:0]                  r_ring_pos;
    logic signed [TOTAL_W-1:0]           r_ring_total;
    logic signed [TEMP_W-1:0]            r_soil_value;
    logic signed [TEMP_W-1:0]            r_sample;
    logic                                r_closed;
    logic signed [TEMP_W-1:0]            r_mean;
    logic [IDX_W-1:0]                    r_idx;
    logic                                r_rd_pend;

    logic signed [TEMP_W-1:0] r_ring [dmmac_pkg::MAX_DAYS];
    logic signed [TEMP_W-1:0] r_rd_data;

    logic                      r_out_valid;
    dmmac_pkg::t_out_item      r_out_data;

    logic [IDX_W-1:0]          period;
    logic                      close_now;
    logic                      saturated;
    logic [RING_AW-1:0]        wr_pos;
    logic [IDX_W-1:0]          wr_pos_inc;
    logic                      ring_we;
    logic [RING_AW-1:0]        ring_wa;
    logic                      div_load;
    logic signed [DIV_W-1:0]   div_dividend;
    logic [dmmac_pkg::COUNT_BITS-1:0] div_divisor;
    logic                      div_busy;
    logic signed [DIV_W-1:0]   div_quotient;
    logic signed [DIV_W-1:0]   max_x;
    logic signed [DIV_W-1:0]   min_x;
    logic signed [DIV_W-1:0]   upper_lim;
    logic signed [DIV_W-1:0]   clamped;
    logic                      out_free;

    assign period    = dmmac_pkg::period_of(r_avg_period);
    assign close_now = i_in_data.at_midnight && (r_step_count != '0);
    assign saturated = (r_step_count == dmmac_pkg::COUNT_MAX);
    assign out_free  = !r_out_valid || i_out_ready;

    // slot for a single write after the fill
    assign wr_pos     = ({1'b0, r_ring_pos} >= period) ? '0 : r_ring_pos;
    assign wr_pos_inc = {1'b0, wr_pos} + 1'b1;

    assign ring_we = i_cmd.fill_step || i_cmd.write_one;
    assign ring_wa = i_cmd.fill_step ? r_idx[RING_AW-1:0] : wr_pos;

    assign div_load     = (i_cmd.accept && close_now) || i_cmd.load_avg;
    assign div_dividend = i_cmd.load_avg
                        ? {{(DIV_W-TOTAL_W){r_ring_total[TOTAL_W-1]}}, r_ring_total}
                        : r_day_sum;
    assign div_divisor  = i_cmd.load_avg
                        ? {{(dmmac_pkg::COUNT_BITS-IDX_W){1'b0}}, period}
                        : r_step_count;

    dmmac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (div_load),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quotient)
    );

    // clamp: limit to max first, then raise to min
    assign max_x     = {{(DIV_W-TEMP_W){r_max_temp[TEMP_W-1]}}, r_max_temp};
    assign min_x     = {{(DIV_W-TEMP_W){r_min_temp[TEMP_W-1]}}, r_min_temp};
    assign upper_lim = (div_quotient > max_x) ? max_x : div_quotient;
    assign clamped   = (upper_lim < min_x) ? min_x : upper_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_period <= dmmac_pkg::AVG_PERIOD_RST;
            r_min_temp   <= dmmac_pkg::MIN_TEMP_RST;
            r_max_temp   <= dmmac_pkg::MAX_TEMP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dmmac_pkg::CFG_AVG_PERIOD: begin
                    r_avg_period <= i_cfg_data[dmmac_pkg::PERIOD_W-1:0];
                end
                dmmac_pkg::CFG_MIN_TEMP: begin
                    r_min_temp <= $signed(i_cfg_data[TEMP_W-1:0]);
                end
                dmmac_pkg::CFG_MAX_TEMP: begin
                    r_max_temp <= $signed(i_cfg_data[TEMP_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day_sum    <= '0;
            r_step_count <= '0;
            r_need_fill  <= 1'b1;
            r_ring_pos   <= '0;
            r_ring_total <= '0;
            r_soil_value <= '0;
            r_idx        <= '0;
            r_rd_pend    <= 1'b0;
            r_closed     <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_closed <= close_now;
                if (!close_now && !saturated) begin
                    r_day_sum    <= r_day_sum
                                  + {{(SUM_W-TEMP_W){i_in_data.outdoor_temp[TEMP_W-1]}},
                                     i_in_data.outdoor_temp};
                    r_step_count <= r_step_count + 1'b1;
                end
            end
            if (i_cmd.take_mean) begin
                r_idx        <= '0;
                r_ring_total <= '0;
                r_rd_pend    <= 1'b0;
            end
            if (i_cmd.fill_step) begin
                r_idx        <= r_idx + 1'b1;
                r_ring_total <= r_ring_total
                              + {{(TOTAL_W-TEMP_W){r_mean[TEMP_W-1]}}, r_mean};
                if (r_idx == period - 1'b1) begin
                    r_need_fill <= 1'b0;
                    r_ring_pos  <= '0;
                end
            end
            if (i_cmd.write_one) begin
                r_ring_pos <= (wr_pos_inc >= period) ? '0 : wr_pos_inc[RING_AW-1:0];
            end
            if (i_cmd.sum_step) begin
                if (r_idx < period) begin
                    r_idx     <= r_idx + 1'b1;
                    r_rd_pend <= 1'b1;
                end else begin
                    r_rd_pend <= 1'b0;
                end
                if (r_rd_pend) begin
                    r_ring_total <= r_ring_total
                                  + {{(TOTAL_W-TEMP_W){r_rd_data[TEMP_W-1]}}, r_rd_data};
                end
            end
            if (i_cmd.finish) begin
                r_soil_value <= clamped[TEMP_W-1:0];
                // the midnight sample opens the new day
                r_day_sum    <= {{(SUM_W-TEMP_W){r_sample[TEMP_W-1]}}, r_sample};
                r_step_count <= dmmac_pkg::COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_in_data.outdoor_temp;
        end
        if (i_cmd.take_mean) begin
            r_mean <= div_quotient[TEMP_W-1:0];
        end
    end

    // ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_wa] <= r_mean;
        end
        r_rd_data <= r_ring[r_idx[RING_AW-1:0]];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.soil_temp  <= r_soil_value;
            r_out_data.day_closed <= r_closed;
        end
    end

    assign o_sts.close_now = close_now;
    assign o_sts.div_busy  = div_busy;
    assign o_sts.need_fill = r_need_fill;
    assign o_sts.fill_last = (r_idx == period - 1'b1);
    assign o_sts.sum_done  = (r_idx == period) && !r_rd_pend;
    assign o_sts.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== sv/dmmac_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmmac_ctrl
// Controller: sequences accept, mean division, ring update, ring sum,
// average division and the result beat.
// ----------------------------------------------------------------------------
module dmmac_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dmmac_pkg::t_sts    i_sts,
    output dmmac_pkg::t_cmd    o_cmd
);

    dmmac_pkg::t_state r_state;
    dmmac_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmmac_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            dmmac_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_sts.close_now ? dmmac_pkg::ST_DIV_MEAN : dmmac_pkg::ST_EMIT;
                end
            end
            dmmac_pkg::ST_DIV_MEAN: begin
                if (!i_sts.div_busy) begin
                    o_cmd.take_mean = 1'b1;
                    n_state = i_sts.need_fill ? dmmac_pkg::ST_FILL : dmmac_pkg::ST_WRITE;
                end
            end
            dmmac_pkg::ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = dmmac_pkg::ST_AVG_LOAD;
                end
            end
            dmmac_pkg::ST_WRITE: begin
                o_cmd.write_one = 1'b1;
                n_state = dmmac_pkg::ST_SUM;
            end
            dmmac_pkg::ST_SUM: begin
                if (i_sts.sum_done) begin
                    n_state = dmmac_pkg::ST_AVG_LOAD;
                end else begin
                    o_cmd.sum_step = 1'b1;
                end
            end
            dmmac_pkg::ST_AVG_LOAD: begin
                o_cmd.load_avg = 1'b1;
                n_state = dmmac_pkg::ST_DIV_AVG;
            end
            dmmac_pkg::ST_DIV_AVG: begin
                if (!i_sts.div_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = dmmac_pkg::ST_EMIT;
                end
            end
            dmmac_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = dmmac_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dmmac_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == dmmac_pkg::ST_IDLE);

endmodule
